// ===== rtl/core/wgm_pkg.sv =====
package wgm_pkg;

  localparam int unsigned MaxPatternDef = 32;

  localparam logic [7:0] StarChar  = 8'd42;
  localparam logic [7:0] QuestChar = 8'd63;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_START  = 2'd2,
    FUNC_TEXT   = 2'd3
  } func_e;

  // one sweep token travelling down the cell row
  typedef struct packed {
    logic       active;
    logic       text;      // 1: text byte update, 0: empty-text recompute
    logic       emit;      // produce a result at the end of the row
    logic       last;
    logic [7:0] c;
    logic       prev_new;  // updated bit of the left neighbour
    logic       prev_old;  // bit of the left neighbour before this sweep
    logic       res;       // bit at the pattern length, picked up on the way
  } wave_t;

endpackage

// ===== rtl/core/wgm_in_if.sv =====
interface wgm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_in;
  logic       last;

  modport source (output valid, output func, output char_in, output last, input ready);
  modport sink   (input valid, input func, input char_in, input last, output ready);
endinterface

// ===== rtl/core/wgm_out_if.sv =====
interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;
  logic last_out;

  modport source (output valid, output matched, output pattern_overflow, output last_out,
                  input ready);
  modport sink   (input valid, input matched, input pattern_overflow, input last_out,
                  output ready);
endinterface

// ===== rtl/core/wgm_cell.sv =====
module wgm_cell import wgm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPatternDef,
  parameter int unsigned IDX         = 1,
  localparam int unsigned LenW       = $clog2(MAX_PATTERN + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic [LenW-1:0] len_i,
  input  logic            char_we_i,
  input  logic [7:0]      char_i,
  input  wave_t           wave_i,
  output wave_t           wave_o
);

  logic [7:0] pbyte_q;
  logic       vbit_q, vbit_d;
  wave_t      wave_q, wave_d;
  logic       in_pat, is_star, v;

  always_comb begin
    in_pat  = (len_i >= LenW'(IDX));
    is_star = (pbyte_q == StarChar);
    if (wave_i.text) begin
      if (is_star) begin
        v = in_pat && (vbit_q || wave_i.prev_new);
      end else begin
        v = in_pat && wave_i.prev_old && ((pbyte_q == QuestChar) || (pbyte_q == wave_i.c));
      end
    end else begin
      v = in_pat && is_star && wave_i.prev_new;
    end

    wave_d          = wave_i;
    wave_d.prev_new = v;
    wave_d.prev_old = vbit_q;
    if (len_i == LenW'(IDX)) begin
      wave_d.res = v;
    end
    vbit_d = (wave_i.active) ? v : vbit_q;
  end

  always_ff @(posedge clk_i) begin
    if (char_we_i && (len_i == LenW'(IDX - 1))) begin
      pbyte_q <= char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbit_q <= 1'b0;
      wave_q <= '0;
    end else if (advance_i) begin
      vbit_q <= vbit_d;
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

endmodule

// ===== rtl/core/wildcard_glob_matcher.sv =====
// Streamed wildcard matcher: '*' matches any run of bytes (also empty), '?' any one byte.
// Load the pattern with clear and append transactions, then send start and text bytes;
// start and every text byte return one result telling whether the whole pattern matches
// the text since start. Clear and an append once the pattern is full send no token and
// keep the input ready (the byte is dropped and pattern_overflow stays set until the next
// clear). Every other transaction sends a token down the row of MAX_PATTERN pattern cells,
// one cell per cycle while the last cell is not stalled by an untaken result, and the
// block takes no new transaction until the token has left the last cell.
module wildcard_glob_matcher import wgm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPatternDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  wgm_in_if.sink    in_i,
  wgm_out_if.source out_o
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            bit0_q, bit0_d;
  logic            busy_q, busy_d;
  wave_t           inj_q, inj_d;
  logic            char_we;
  logic            advance;
  logic            accept;
  logic            out_valid_q, out_valid_d;
  logic            matched_q, ovf_out_q, last_out_q;
  logic            load_out;

  wave_t chain [MAX_PATTERN+1];

  assign chain[0] = inj_q;

  for (genvar g = 1; g <= MAX_PATTERN; g++) begin : g_cell
    wgm_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .IDX         (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .len_i     (len_q),
      .char_we_i (char_we),
      .char_i    (in_i.char_in),
      .wave_i    (chain[g-1]),
      .wave_o    (chain[g])
    );
  end

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;

  always_comb begin
    advance  = !(chain[MAX_PATTERN].active && chain[MAX_PATTERN].emit &&
                 out_valid_q && !out_o.ready);
    load_out = chain[MAX_PATTERN].active && chain[MAX_PATTERN].emit && advance;

    len_d   = len_q;
    ovf_d   = ovf_q;
    bit0_d  = bit0_q;
    busy_d  = busy_q;
    char_we = 1'b0;

    inj_d          = '0;
    inj_d.last     = in_i.last;
    inj_d.c        = in_i.char_in;
    inj_d.prev_old = bit0_q;

    if (chain[MAX_PATTERN].active && advance) begin
      busy_d = 1'b0;
    end

    if (accept) begin
      case (func_e'(in_i.func))
        FUNC_CLEAR: begin
          len_d  = '0;
          ovf_d  = 1'b0;
          bit0_d = 1'b1;
        end
        FUNC_APPEND: begin
          if (len_q < LenW'(MAX_PATTERN)) begin
            char_we        = 1'b1;
            len_d          = len_q + LenW'(1);
            inj_d.active   = 1'b1;
            inj_d.prev_new = 1'b1;
            bit0_d         = 1'b1;
            busy_d         = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        FUNC_START: begin
          inj_d.active   = 1'b1;
          inj_d.emit     = 1'b1;
          inj_d.prev_new = 1'b1;
          inj_d.res      = (len_q == '0);
          bit0_d         = 1'b1;
          busy_d         = 1'b1;
        end
        FUNC_TEXT: begin
          inj_d.active   = 1'b1;
          inj_d.emit     = 1'b1;
          inj_d.text     = 1'b1;
          bit0_d         = 1'b0;
          busy_d         = 1'b1;
        end
        default: begin
          busy_d = busy_q;
        end
      endcase
    end

    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      bit0_q      <= 1'b1;
      busy_q      <= 1'b0;
      inj_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      bit0_q      <= bit0_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        inj_q <= inj_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      matched_q  <= chain[MAX_PATTERN].res;
      ovf_out_q  <= ovf_q;
      last_out_q <= chain[MAX_PATTERN].last;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = matched_q;
  assign out_o.pattern_overflow = ovf_out_q;
  assign out_o.last_out         = last_out_q;

endmodule

// ===== rtl/core/wgm_checker.sv =====
module wgm_checker import wgm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_func_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_matched_i,
  input logic       out_ovf_i,
  input logic       out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_matched_i) &&
      $stable(out_ovf_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
      (in_func_i == FUNC_START || in_func_i == FUNC_TEXT) |=> !in_ready_i)
    else $error("ready during sweep");

  a_clear_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == FUNC_CLEAR) |=> in_ready_i)
    else $error("clear transaction blocked the input");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid in reset");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_func_i     (in_i.func),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_matched_i (out_o.matched),
  .out_ovf_i     (out_o.pattern_overflow),
  .out_last_i    (out_o.last_out)
);
